// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file swc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SWC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// property checked at every clock edge, reset included
`define SWC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/swc_pkg.sv =====
// types, constants and the stop word table of the stop word counter
`timescale 1ns / 1ps
`default_nettype none
package swc_pkg;

    localparam int NUM_STOP_WORDS = 25;
    localparam int TABLE_SLOTS    = 32;
    localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
    localparam int COUNT_BITS     = 32;
    localparam int REPORT_BITS    = 32;
    localparam int WORD_BYTES     = 4;
    localparam int WORD_BITS      = 8 * WORD_BYTES;

    // word length codes: 0..4 held characters, LEN_LONG once past four
    localparam logic [2:0] LEN_EMPTY = 3'd0;
    localparam logic [2:0] LEN_FULL  = 3'd4;
    localparam logic [2:0] LEN_LONG  = 3'd5;

    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [REPORT_BITS-1:0] t_report;
    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [2:0]             t_len;

    typedef struct packed {
        logic [7:0] character;
        logic       has_character;
        logic       text_end;
        logic       list_end;
    } t_in_item;

    typedef struct packed {
        t_report text_count;
        t_report stop_word_count;
    } t_out_item;

    typedef struct packed {
        t_len  len;
        t_word bytes;
    } t_stop_entry;

    // first character in the low byte; empty slots have length zero
    function automatic t_stop_entry stop_entry(input logic [SLOT_BITS-1:0] idx);
        t_stop_entry e;
        case (idx)
            5'd0:    e = '{3'd1, {8'd0, 8'd0, 8'd0, "a"}};
            5'd1:    e = '{3'd2, {8'd0, 8'd0, "n", "a"}};
            5'd2:    e = '{3'd3, {8'd0, "d", "n", "a"}};
            5'd3:    e = '{3'd3, {8'd0, "e", "r", "a"}};
            5'd4:    e = '{3'd2, {8'd0, 8'd0, "s", "a"}};
            5'd5:    e = '{3'd2, {8'd0, 8'd0, "t", "a"}};
            5'd6:    e = '{3'd2, {8'd0, 8'd0, "e", "b"}};
            5'd7:    e = '{3'd2, {8'd0, 8'd0, "y", "b"}};
            5'd8:    e = '{3'd3, {8'd0, "r", "o", "f"}};
            5'd9:    e = '{3'd4, {"m", "o", "r", "f"}};
            5'd10:   e = '{3'd3, {8'd0, "s", "a", "h"}};
            5'd11:   e = '{3'd2, {8'd0, 8'd0, "e", "h"}};
            5'd12:   e = '{3'd2, {8'd0, 8'd0, "n", "i"}};
            5'd13:   e = '{3'd2, {8'd0, 8'd0, "s", "i"}};
            5'd14:   e = '{3'd2, {8'd0, 8'd0, "t", "i"}};
            5'd15:   e = '{3'd3, {8'd0, "s", "t", "i"}};
            5'd16:   e = '{3'd2, {8'd0, 8'd0, "f", "o"}};
            5'd17:   e = '{3'd2, {8'd0, 8'd0, "n", "o"}};
            5'd18:   e = '{3'd4, {"t", "a", "h", "t"}};
            5'd19:   e = '{3'd3, {8'd0, "e", "h", "t"}};
            5'd20:   e = '{3'd2, {8'd0, 8'd0, "o", "t"}};
            5'd21:   e = '{3'd3, {8'd0, "s", "a", "w"}};
            5'd22:   e = '{3'd4, {"e", "r", "e", "w"}};
            5'd23:   e = '{3'd4, {"l", "l", "i", "w"}};
            5'd24:   e = '{3'd4, {"h", "t", "i", "w"}};
            default: e = '{LEN_EMPTY, '0};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/swc_in_if.sv =====
// request channel carrying one text character item
`timescale 1ns / 1ps
`default_nettype none
interface swc_in_if;
    import swc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/swc_out_if.sv =====
// request channel carrying one pair of list counts
`timescale 1ns / 1ps
`default_nettype none
interface swc_out_if;
    import swc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/swc_match.sv =====
// parallel compare of the finished word against the stop word table
`timescale 1ns / 1ps
`default_nettype none
module swc_match (
    input  swc_pkg::t_word i_word_chars,
    input  swc_pkg::t_len  i_word_len,
    output logic           o_hit
);
    import swc_pkg::*;

    t_stop_entry entry;

    always_comb begin
        o_hit = 1'b0;
        entry = '{LEN_EMPTY, '0};
        for (int i = 0; i < NUM_STOP_WORDS && i < TABLE_SLOTS; i++) begin
            entry = stop_entry(SLOT_BITS'(i));
            if (entry.len == i_word_len && entry.bytes == i_word_chars &&
                i_word_len != LEN_EMPTY) begin
                o_hit = 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/stop_word_counter.sv =====
// top level of the stop word counter
`timescale 1ns / 1ps
`default_nettype none
// Stop word counter. Takes one character request per clock and splits each
// text into words at space, comma, period, hyphen, colon, semicolon and the
// zero byte; a word also ends at the end of a text. Every word of one to four
// characters is compared exactly (case-sensitive) with a fixed table of 25
// stop words; longer words never match. Texts and matching words are counted
// in saturating counters, and a request with list_end set produces one result
// request with both counts and then clears them (list_end also closes the
// current text, with or without text_end). Throughput is one character per
// cycle while the input side does not stall: a request lands in an input
// register, the word update, table compare and counter update then work on
// it, and a list end loads its result into the output register, where it
// waits until the sink takes it. The input side stalls only while a list
// end sits in the input register behind a result that has not been taken yet.
module stop_word_counter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swc_in_if.sink    i_in,
    swc_out_if.source o_out
);
    import swc_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam t_count COUNT_MAX = '1;

    function automatic logic is_delim(input logic [7:0] c);
        return c == CH_SPACE || c == CH_COMMA || c == CH_DOT || c == CH_DASH ||
               c == CH_COLON || c == CH_SEMI || c == CH_NUL;
    endfunction

    // counts wider than the result field clamp to all ones
    function automatic t_report report(input t_count v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide[63:REPORT_BITS] != '0) begin
            return '1;
        end
        return wide[REPORT_BITS-1:0];
    endfunction

    function automatic t_count sat_inc(input t_count v, input logic inc);
        if (inc && v != COUNT_MAX) begin
            return v + t_count'(1);
        end
        return v;
    endfunction

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // word and count state
    t_word  r_word_chars, n_word_chars;
    t_len   r_word_len,   n_word_len;
    t_count r_texts,      n_texts;
    t_count r_matches,    n_matches;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    logic   out_free;
    logic   advance;
    logic   process;
    logic   delim;
    logic   text_done;
    logic   word_done;
    t_word  eval_chars;
    t_len   eval_len;
    logic   hit;
    t_count texts_inc;
    t_count matches_inc;

    // the result register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;
    // only a list end needs room in the result register
    assign advance  = !r_in_valid || !r_in.list_end || out_free;
    assign process  = r_in_valid && advance;
    assign i_in.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in.valid) begin
            r_in <= i_in.payload;
        end
    end

    // word seen after this character: appended when it is a word character
    always_comb begin
        delim      = r_in.has_character && is_delim(r_in.character);
        text_done  = r_in.text_end || r_in.list_end;
        eval_chars = r_word_chars;
        eval_len   = r_word_len;
        if (r_in.has_character && !delim) begin
            if (r_word_len < LEN_FULL) begin
                for (int b = 0; b < WORD_BYTES; b++) begin
                    if (r_word_len[1:0] == 2'(b)) begin
                        eval_chars[8*b +: 8] = r_in.character;
                    end
                end
                eval_len = r_word_len + t_len'(1);
            end else begin
                eval_len = LEN_LONG;
            end
        end
        // a delimiter closes the held word, then a text end finds it empty
        word_done = delim || text_done;
    end

    swc_match u_match (
        .i_word_chars (delim ? r_word_chars : eval_chars),
        .i_word_len   (delim ? r_word_len   : eval_len),
        .o_hit        (hit)
    );

    always_comb begin
        texts_inc    = sat_inc(r_texts, text_done);
        matches_inc  = sat_inc(r_matches, word_done && hit);
        n_word_chars = word_done ? '0 : eval_chars;
        n_word_len   = word_done ? LEN_EMPTY : eval_len;
        n_texts      = r_in.list_end ? '0 : texts_inc;
        n_matches    = r_in.list_end ? '0 : matches_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_chars <= '0;
            r_word_len   <= LEN_EMPTY;
            r_texts      <= '0;
            r_matches    <= '0;
        end else if (process) begin
            r_word_chars <= n_word_chars;
            r_word_len   <= n_word_len;
            r_texts      <= n_texts;
            r_matches    <= n_matches;
        end
    end

    // result register, loaded by a list end and held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && r_in.list_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && r_in.list_end) begin
            r_out.text_count      <= report(texts_inc);
            r_out.stop_word_count <= report(matches_inc);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
endmodule
`default_nettype wire

// ===== hdl/swc_checker.sv =====
// port-level checks of the stop word counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module swc_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire swc_pkg::t_out_item i_out_payload
);
    import swc_pkg::*;

    // no result request appears straight out of reset
    `SWC_ASSERT_ALWAYS(a_out_idle_after_reset, i_clk, !i_rst_n |=> !i_out_valid)

    // a stalled result keeps its counts
    `SWC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))

    // every reported list holds at least the closing text
    `SWC_ASSERT(a_text_count_nonzero, i_clk, i_rst_n, i_out_valid |-> (i_out_payload.text_count != '0))

    // with the result register empty the input side never stalls
    `SWC_ASSERT(a_ready_when_out_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)
endmodule

bind stop_word_counter swc_checker u_swc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
`default_nettype wire
